>>> hdl/llss_pkg.sv
// Shared types and constants for the least-loaded server selector.
`default_nettype none

package llss_pkg;

    typedef enum logic [2:0] {
        OP_SELECT   = 3'd0,
        OP_REPORT   = 3'd1,
        OP_COMPLETE = 3'd2,
        OP_FAIL     = 3'd3,
        OP_TICK     = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD_RD,
        ST_EXEC,
        ST_FINISH
    } state_t;

    localparam int OPCODE_W    = 3;
    localparam int SRV_IDX_W   = 4;
    localparam int RPT_CNT_W   = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_SRV_W   = 5;
    localparam int CHK_W       = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_SERVERS        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUESTS_PER_CHECK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_PERIOD       = 2'd2;

    localparam logic [NUM_SRV_W-1:0] NUM_SERVERS_RST        = 5'd1;
    localparam logic [CHK_W-1:0]     REQUESTS_PER_CHECK_RST = 8'd5;
    localparam logic [CHK_W-1:0]     CHECK_PERIOD_RST       = 8'd3;
    localparam logic [CHK_W-1:0]     CHK_MAX                = 8'hFF;

endpackage

`default_nettype wire

>>> hdl/llss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module llss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/llss_cmp.sv
// Shared ordering unit: fewer requests first, then fewer fails.
`default_nettype none

module llss_cmp #(
    parameter int W = 16
) (
    input  wire logic [W-1:0] cand_req,
    input  wire logic [W-1:0] cand_fail,
    input  wire logic [W-1:0] best_req,
    input  wire logic [W-1:0] best_fail,
    output logic              better
);

    always_comb
    begin
        better = (cand_req < best_req) ||
                 ((cand_req == best_req) && (cand_fail < best_fail));
    end

endmodule

`default_nettype wire

>>> hdl/least_loaded_server_selector.sv
// Least-loaded server selector: server table, sequencer and health-check counters.
//
// Requests come in on in_valid/in_ready with an opcode and operands; every
// request gives exactly one result on out_valid/out_ready. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// The block takes one request at a time: in_ready is high only when the
// sequencer is idle. States from accept to out_valid:
//   select      : scan, then finish; the table RAM is read one entry per
//                 cycle over min(num_servers, MAX_SERVERS) entries, each
//                 through the single compare unit
//   completion  : update read, execute (read-modify-write of the request
//                 count), then finish
//   other codes : execute, then finish
// in_ready returns in the same cycle the result appears in the output
// register. A stalled receiver holds the result there; the next request
// may be accepted meanwhile but is held at its end until the register frees up.
// Reset clears all alive flags, marks every table entry unwritten (reads
// as zero counts), clears the check counters and loads register defaults.
`default_nettype none

module least_loaded_server_selector #(
    parameter int MAX_SERVERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [llss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [llss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [llss_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [llss_pkg::SRV_IDX_W-1:0]    server_index,
    input  wire logic                              report_ok,
    input  wire logic [llss_pkg::RPT_CNT_W-1:0]    report_fails,
    input  wire logic [llss_pkg::RPT_CNT_W-1:0]    report_requests,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [llss_pkg::SRV_IDX_W-1:0]    chosen_server,
    output logic                                   chosen_valid,
    output logic                                   check_due
);

    localparam int IDX_W  = $clog2(MAX_SERVERS);
    localparam int SCAN_W = (IDX_W >= llss_pkg::NUM_SRV_W) ? IDX_W : IDX_W + 1;
    localparam int WIDE_W = (SCAN_W > llss_pkg::NUM_SRV_W) ? SCAN_W : llss_pkg::NUM_SRV_W;
    localparam int ENT_W  = 2 * COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration
    logic [llss_pkg::NUM_SRV_W-1:0] num_servers_reg;
    logic [llss_pkg::CHK_W-1:0]     requests_per_check_reg;
    logic [llss_pkg::CHK_W-1:0]     check_period_reg;

    // sequencer and request latch
    llss_pkg::state_t               state_reg, state_next;
    llss_pkg::opcode_t              op_reg, op_next;
    logic [llss_pkg::SRV_IDX_W-1:0] idx_reg, idx_next;
    logic                           ok_reg, ok_next;
    logic [COUNT_WIDTH-1:0]         rfails_reg, rfails_next;
    logic [COUNT_WIDTH-1:0]         rreqs_reg, rreqs_next;

    // scan
    logic [SCAN_W-1:0]              scan_reg, scan_next;
    logic                           pend_reg, pend_next;
    logic [IDX_W-1:0]               pend_idx_reg, pend_idx_next;
    logic                           best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    logic [COUNT_WIDTH-1:0]         best_req_reg, best_req_next;
    logic [COUNT_WIDTH-1:0]         best_fail_reg, best_fail_next;

    // table flags and check counters
    logic [MAX_SERVERS-1:0]         alive_reg, alive_next;
    logic [MAX_SERVERS-1:0]         written_reg, written_next;
    logic [llss_pkg::CHK_W-1:0]     completed_reg, completed_next;
    logic [llss_pkg::CHK_W-1:0]     ticks_reg, ticks_next;
    logic                           due_reg, due_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic [llss_pkg::SRV_IDX_W-1:0] chosen_server_reg, chosen_server_next;
    logic                           chosen_valid_reg, chosen_valid_next;
    logic                           check_due_reg, check_due_next;

    // datapath
    logic [WIDE_W-1:0]      num_wide;
    logic [WIDE_W-1:0]      used_wide;
    logic [SCAN_W-1:0]      used;
    logic                   in_range;
    logic [IDX_W-1:0]       idx_addr;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;
    logic [COUNT_WIDTH-1:0] ent_req;
    logic [COUNT_WIDTH-1:0] ent_fail;
    logic                   better;
    logic [llss_pkg::CHK_W-1:0] cnt_inc;

    always_comb
    begin
        num_wide  = WIDE_W'(num_servers_reg);
        used_wide = (num_wide < WIDE_W'(MAX_SERVERS)) ? num_wide : WIDE_W'(MAX_SERVERS);
        used      = SCAN_W'(used_wide);
        in_range  = WIDE_W'(idx_reg) < used_wide;
        idx_addr  = IDX_W'(idx_reg);
    end

    llss_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SERVERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // unwritten entries read as zero counts
    always_comb
    begin
        if (state_reg == llss_pkg::ST_SCAN)
        begin
            ent_req  = written_reg[pend_idx_reg] ? ram_rdata[ENT_W-1:COUNT_WIDTH] : '0;
            ent_fail = written_reg[pend_idx_reg] ? ram_rdata[COUNT_WIDTH-1:0] : '0;
        end
        else
        begin
            ent_req  = written_reg[idx_addr] ? ram_rdata[ENT_W-1:COUNT_WIDTH] : '0;
            ent_fail = written_reg[idx_addr] ? ram_rdata[COUNT_WIDTH-1:0] : '0;
        end
    end

    llss_cmp #(
        .W (COUNT_WIDTH)
    ) u_cmp (
        .cand_req  (ent_req),
        .cand_fail (ent_fail),
        .best_req  (best_req_reg),
        .best_fail (best_fail_reg),
        .better    (better)
    );

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        idx_next           = idx_reg;
        ok_next            = ok_reg;
        rfails_next        = rfails_reg;
        rreqs_next         = rreqs_reg;
        scan_next          = scan_reg;
        pend_next          = pend_reg;
        pend_idx_next      = pend_idx_reg;
        best_valid_next    = best_valid_reg;
        best_idx_next      = best_idx_reg;
        best_req_next      = best_req_reg;
        best_fail_next     = best_fail_reg;
        alive_next         = alive_reg;
        written_next       = written_reg;
        completed_next     = completed_reg;
        ticks_next         = ticks_reg;
        due_next           = due_reg;
        out_valid_next     = out_valid_reg;
        chosen_server_next = chosen_server_reg;
        chosen_valid_next  = chosen_valid_reg;
        check_due_next     = check_due_reg;
        ram_we             = 1'b0;
        ram_waddr          = idx_addr;
        ram_wdata          = {rreqs_reg, rfails_reg};
        ram_raddr          = idx_addr;
        in_ready           = 1'b0;
        cnt_inc            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            llss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = llss_pkg::opcode_t'(opcode);
                    idx_next        = server_index;
                    ok_next         = report_ok;
                    rfails_next     = COUNT_WIDTH'(report_fails);
                    rreqs_next      = COUNT_WIDTH'(report_requests);
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    best_valid_next = 1'b0;
                    best_idx_next   = '0;
                    due_next        = 1'b0;
                    if (opcode == llss_pkg::OP_SELECT)
                    begin
                        state_next = llss_pkg::ST_SCAN;
                    end
                    else if (opcode == llss_pkg::OP_COMPLETE)
                    begin
                        state_next = llss_pkg::ST_UPD_RD;
                    end
                    else
                    begin
                        state_next = llss_pkg::ST_EXEC;
                    end
                end
            end

            llss_pkg::ST_SCAN:
            begin
                // read issue runs one entry ahead of the compare
                ram_raddr = scan_reg[IDX_W-1:0];
                if (pend_reg && alive_reg[pend_idx_reg] && (!best_valid_reg || better))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = pend_idx_reg;
                    best_req_next   = ent_req;
                    best_fail_next  = ent_fail;
                end
                if (scan_reg < used)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + SCAN_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = llss_pkg::ST_FINISH;
                end
            end

            llss_pkg::ST_UPD_RD:
            begin
                state_next = llss_pkg::ST_EXEC;
            end

            llss_pkg::ST_EXEC:
            begin
                state_next = llss_pkg::ST_FINISH;
                case (op_reg)
                    llss_pkg::OP_REPORT:
                    begin
                        if (in_range)
                        begin
                            alive_next[idx_addr] = ok_reg;
                            if (ok_reg)
                            begin
                                ram_we                 = 1'b1;
                                written_next[idx_addr] = 1'b1;
                            end
                        end
                    end
                    llss_pkg::OP_COMPLETE:
                    begin
                        if (in_range && (ent_req < COUNT_MAX))
                        begin
                            ram_we                 = 1'b1;
                            ram_wdata              = {ent_req + COUNT_WIDTH'(1), ent_fail};
                            written_next[idx_addr] = 1'b1;
                        end
                        cnt_inc = (completed_reg < llss_pkg::CHK_MAX) ?
                                  completed_reg + 8'd1 : completed_reg;
                        if ((cnt_inc >= requests_per_check_reg) ||
                            (ticks_reg >= check_period_reg))
                        begin
                            due_next       = 1'b1;
                            completed_next = '0;
                            ticks_next     = '0;
                        end
                        else
                        begin
                            completed_next = cnt_inc;
                        end
                    end
                    llss_pkg::OP_FAIL:
                    begin
                        if (in_range)
                        begin
                            alive_next[idx_addr] = 1'b0;
                        end
                    end
                    llss_pkg::OP_TICK:
                    begin
                        cnt_inc = (ticks_reg < llss_pkg::CHK_MAX) ?
                                  ticks_reg + 8'd1 : ticks_reg;
                        if ((completed_reg >= requests_per_check_reg) ||
                            (cnt_inc >= check_period_reg))
                        begin
                            due_next       = 1'b1;
                            completed_next = '0;
                            ticks_next     = '0;
                        end
                        else
                        begin
                            ticks_next = cnt_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            llss_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    chosen_valid_next  = best_valid_reg;
                    chosen_server_next = best_valid_reg ?
                                         llss_pkg::SRV_IDX_W'(best_idx_reg) : '0;
                    check_due_next     = due_reg;
                    state_next         = llss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = llss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_servers_reg        <= llss_pkg::NUM_SERVERS_RST;
            requests_per_check_reg <= llss_pkg::REQUESTS_PER_CHECK_RST;
            check_period_reg       <= llss_pkg::CHECK_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                llss_pkg::CFG_NUM_SERVERS:
                    num_servers_reg <= cfg_data[llss_pkg::NUM_SRV_W-1:0];
                llss_pkg::CFG_REQUESTS_PER_CHECK:
                    requests_per_check_reg <= cfg_data;
                llss_pkg::CFG_CHECK_PERIOD:
                    check_period_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= llss_pkg::ST_IDLE;
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            alive_reg      <= '0;
            written_reg    <= '0;
            completed_reg  <= '0;
            ticks_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            best_valid_reg <= best_valid_next;
            alive_reg      <= alive_next;
            written_reg    <= written_next;
            completed_reg  <= completed_next;
            ticks_reg      <= ticks_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        idx_reg           <= idx_next;
        ok_reg            <= ok_next;
        rfails_reg        <= rfails_next;
        rreqs_reg         <= rreqs_next;
        scan_reg          <= scan_next;
        pend_idx_reg      <= pend_idx_next;
        best_idx_reg      <= best_idx_next;
        best_req_reg      <= best_req_next;
        best_fail_reg     <= best_fail_next;
        due_reg           <= due_next;
        chosen_server_reg <= chosen_server_next;
        chosen_valid_reg  <= chosen_valid_next;
        check_due_reg     <= check_due_next;
    end

    assign out_valid     = out_valid_reg;
    assign chosen_server = chosen_server_reg;
    assign chosen_valid  = chosen_valid_reg;
    assign check_due     = check_due_reg;

endmodule

`default_nettype wire

>>> hdl/llss_checker.sv
// Port-level assertions for the least-loaded server selector, bound to the top level.
`default_nettype none

module llss_assertions (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_we,
    input wire logic [llss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input wire logic [llss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic [llss_pkg::OPCODE_W-1:0]     opcode,
    input wire logic [llss_pkg::SRV_IDX_W-1:0]    server_index,
    input wire logic                              report_ok,
    input wire logic [llss_pkg::RPT_CNT_W-1:0]    report_fails,
    input wire logic [llss_pkg::RPT_CNT_W-1:0]    report_requests,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [llss_pkg::SRV_IDX_W-1:0]    chosen_server,
    input wire logic                              chosen_valid,
    input wire logic                              check_due
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_server) &&
        $stable(chosen_valid) && $stable(check_due))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a request while busy");

    a_none_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chosen_valid |-> chosen_server == '0)
        else $error("server index set without a valid choice");

    // a successful select never flags a health check
    a_select_no_due: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chosen_valid |-> !check_due)
        else $error("check_due raised on a select");

endmodule

bind least_loaded_server_selector llss_assertions u_llss_assertions (.*);

`default_nettype wire

>>> sim/llss_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the server selector: mirrors the server table, predicts and compares results.
module llss_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [llss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [llss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic [llss_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [llss_pkg::SRV_IDX_W-1:0]    server_index,
    input  wire logic                              report_ok,
    input  wire logic [llss_pkg::RPT_CNT_W-1:0]    report_fails,
    input  wire logic [llss_pkg::RPT_CNT_W-1:0]    report_requests,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic [llss_pkg::SRV_IDX_W-1:0]    chosen_server,
    input  wire logic                              chosen_valid,
    input  wire logic                              check_due,
    output int                                     errors,
    output int                                     outstanding
);
    import llss_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam logic [RPT_CNT_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [SRV_IDX_W-1:0] server;
        logic                 found;
        logic                 due;
    } selection_t;

    logic                 alive    [TABLE_DEPTH];
    logic [RPT_CNT_W-1:0] req_cnt  [TABLE_DEPTH];
    logic [RPT_CNT_W-1:0] fail_cnt [TABLE_DEPTH];
    logic [CHK_W-1:0]     done_cnt;
    logic [CHK_W-1:0]     tick_cnt;
    logic [NUM_SRV_W-1:0] servers_cfg;
    logic [CHK_W-1:0]     done_limit;
    logic [CHK_W-1:0]     tick_limit;
    selection_t           pending_results [$];
    selection_t           want;

    function automatic int servers_in_use();
        return (int'(servers_cfg) < TABLE_DEPTH) ? int'(servers_cfg) : TABLE_DEPTH;
    endfunction

    // both counters clear together once either threshold is met
    function automatic logic health_check_due();
        if (done_cnt >= done_limit || tick_cnt >= tick_limit)
        begin
            done_cnt = '0;
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic selection_t serve_request(
        input logic [OPCODE_W-1:0]  op,
        input logic [SRV_IDX_W-1:0] idx,
        input logic                 ok,
        input logic [RPT_CNT_W-1:0] fails,
        input logic [RPT_CNT_W-1:0] reqs
    );
        selection_t res;
        int         used;
        logic       hit;
        res  = '0;
        used = servers_in_use();
        hit  = int'(idx) < used;
        case (op)
            OP_SELECT:
            begin
                for (int i = 0; i < used; i++)
                begin
                    if (alive[i] && (!res.found || req_cnt[i] < req_cnt[res.server] ||
                        (req_cnt[i] == req_cnt[res.server] &&
                         fail_cnt[i] < fail_cnt[res.server])))
                    begin
                        res.server = SRV_IDX_W'(i);
                        res.found  = 1'b1;
                    end
                end
            end
            OP_REPORT:
            begin
                if (hit)
                begin
                    alive[idx] = ok;
                    if (ok)
                    begin
                        fail_cnt[idx] = fails;
                        req_cnt[idx]  = reqs;
                    end
                end
            end
            OP_COMPLETE:
            begin
                if (hit && req_cnt[idx] != COUNT_SAT)
                    req_cnt[idx] = req_cnt[idx] + 1'b1;
                if (done_cnt != CHK_MAX)
                    done_cnt = done_cnt + 1'b1;
                res.due = health_check_due();
            end
            OP_FAIL:
            begin
                if (hit)
                    alive[idx] = 1'b0;
            end
            OP_TICK:
            begin
                if (tick_cnt != CHK_MAX)
                    tick_cnt = tick_cnt + 1'b1;
                res.due = health_check_due();
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                alive[i]    = 1'b0;
                req_cnt[i]  = '0;
                fail_cnt[i] = '0;
            end
            done_cnt    = '0;
            tick_cnt    = '0;
            servers_cfg = NUM_SERVERS_RST;
            done_limit  = REQUESTS_PER_CHECK_RST;
            tick_limit  = CHECK_PERIOD_RST;
            pending_results.delete();
            errors      = 0;
            outstanding <= 0;
        end
        else
        begin
            // result side first: a result never belongs to a request taken at the same edge
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request pending: chosen_server %0d", chosen_server);
                    errors = errors + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (chosen_server !== want.server)
                    begin
                        $error("chosen_server: expected %0d, got %0d", want.server, chosen_server);
                        errors = errors + 1;
                    end
                    if (chosen_valid !== want.found)
                    begin
                        $error("chosen_valid: expected %0d, got %0d", want.found, chosen_valid);
                        errors = errors + 1;
                    end
                    if (check_due !== want.due)
                    begin
                        $error("check_due: expected %0d, got %0d", want.due, check_due);
                        errors = errors + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_SERVERS:        servers_cfg = cfg_data[NUM_SRV_W-1:0];
                    CFG_REQUESTS_PER_CHECK: done_limit  = cfg_data;
                    CFG_CHECK_PERIOD:       tick_limit  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                pending_results.push_back(serve_request(opcode, server_index, report_ok,
                                                        report_fails, report_requests));
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> sim/tb_least_loaded_server_selector.sv
`timescale 1ns / 100ps
// Testbench top for the server selector: request stimulus, register phases and verdict.
module tb_least_loaded_server_selector;
    import llss_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RESERVED_LAST  = 3'd7;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int LONG_HOLD       = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [SRV_IDX_W-1:0]   server_index;
    logic                   report_ok;
    logic [RPT_CNT_W-1:0]   report_fails;
    logic [RPT_CNT_W-1:0]   report_requests;
    logic                   out_valid;
    logic                   out_ready;
    logic [SRV_IDX_W-1:0]   chosen_server;
    logic                   chosen_valid;
    logic                   check_due;
    int                     errors;
    int                     outstanding;

    bit sender_gaps;
    bit calm;
    bit want_long_hold;
    int servers_used;

    // register settings per random phase: servers, completions per check, tick period
    int phase_servers [PHASES] = '{16, 4, 31, 1, 8, 0, 12, 16, 3, 16};
    int phase_done    [PHASES] = '{255, 3, 0, 1, 10, 7, 255, 2, 5, 6};
    int phase_ticks   [PHASES] = '{255, 1, 2, 0, 5, 4, 3, 20, 3, 2};

    least_loaded_server_selector dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .server_index    (server_index),
        .report_ok       (report_ok),
        .report_fails    (report_fails),
        .report_requests (report_requests),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_server   (chosen_server),
        .chosen_valid    (chosen_valid),
        .check_due       (check_due)
    );

    llss_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .server_index    (server_index),
        .report_ok       (report_ok),
        .report_fails    (report_fails),
        .report_requests (report_requests),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_server   (chosen_server),
        .chosen_valid    (chosen_valid),
        .check_due       (check_due),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result receiver: random stall bursts, one long hold-off on request, none when calm
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (calm)
                out_ready = 1'b1;
            else if (want_long_hold)
            begin
                want_long_hold = 1'b0;
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
                out_ready = 1'b1;
        end
    end

    // called at a falling edge; returns at a falling edge once the request is taken, after a random gap if sender_gaps
    task automatic send_request(
        input logic [OPCODE_W-1:0]  op,
        input logic [SRV_IDX_W-1:0] idx,
        input logic                 ok,
        input logic [RPT_CNT_W-1:0] fails,
        input logic [RPT_CNT_W-1:0] reqs
    );
        opcode          = op;
        server_index    = idx;
        report_ok       = ok;
        report_fails    = fails;
        report_requests = reqs;
        in_valid        = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    function automatic logic [RPT_CNT_W-1:0] pick_count();
        case ($urandom_range(0, 3))
            0, 1:    return RPT_CNT_W'($urandom_range(0, 7));
            2:       return RPT_CNT_W'($urandom_range(0, 65535));
            default: return RPT_CNT_W'($urandom_range(65520, 65535));
        endcase
    endfunction

    task automatic random_request();
        int                   pick;
        logic [OPCODE_W-1:0]  op;
        logic [SRV_IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (servers_used > 0 && $urandom_range(0, 9) < 8)
            idx = SRV_IDX_W'($urandom_range(0, servers_used - 1));
        else
            idx = SRV_IDX_W'($urandom_range(0, 15));
        if (pick < 30)
            op = OP_SELECT;
        else if (pick < 55)
            op = OP_REPORT;
        else if (pick < 75)
            op = OP_COMPLETE;
        else if (pick < 83)
            op = OP_FAIL;
        else if (pick < 95)
            op = OP_TICK;
        else
            op = OPCODE_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        // mostly healthy reports so that selects have live servers to choose from
        send_request(op, idx, $urandom_range(0, 5) != 0, pick_count(), pick_count());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic reconfigure(input int servers, input int done_lim, input int tick_lim);
        in_valid = 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge clk);
        write_reg(CFG_NUM_SERVERS, CFG_DATA_W'(servers));
        write_reg(CFG_REQUESTS_PER_CHECK, CFG_DATA_W'(done_lim));
        write_reg(CFG_CHECK_PERIOD, CFG_DATA_W'(tick_lim));
        servers_used = (servers < 16) ? servers : 16;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_NUM_SERVERS;
        cfg_data        = '0;
        in_valid        = 1'b0;
        opcode          = OP_SELECT;
        server_index    = '0;
        report_ok       = 1'b0;
        report_fails    = '0;
        report_requests = '0;
        sender_gaps     = 1'b1;
        calm            = 1'b0;
        want_long_hold  = 1'b0;
        servers_used    = 1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: one server, check after 5 completions or 3 ticks
        send_request(OP_SELECT, 4'd0, 1'b0, 16'd0, 16'd0);
        send_request(OP_REPORT, 4'd0, 1'b1, 16'hFFFF, 16'hFFFE);
        send_request(OP_COMPLETE, 4'd0, 1'b0, 16'd0, 16'd0);
        send_request(OP_COMPLETE, 4'd0, 1'b0, 16'd0, 16'd0);   // request count saturates
        send_request(OP_SELECT, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF);
        send_request(OP_REPORT, 4'd1, 1'b1, 16'd1, 16'd1);     // entry not in use
        send_request(OP_FAIL, 4'd5, 1'b0, 16'd0, 16'd0);
        send_request(OP_COMPLETE, 4'd9, 1'b0, 16'd0, 16'd0);   // still counts as completion
        repeat (3) send_request(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0);
        for (int k = OP_RESERVED_FIRST; k <= OP_RESERVED_LAST; k++)
            send_request(OPCODE_W'(k), '1, 1'b1, '1, '1);
        send_request(OP_REPORT, 4'd0, 1'b0, 16'd7, 16'd7);     // dead report keeps counts
        send_request(OP_SELECT, 4'd0, 1'b0, 16'd0, 16'd0);

        reconfigure(16, 0, 255);
        send_request(OP_REPORT, 4'd15, 1'b1, 16'd3, 16'd2);
        send_request(OP_REPORT, 4'd7, 1'b1, 16'd3, 16'd2);     // tie goes to lower index
        send_request(OP_REPORT, 4'd12, 1'b1, 16'd1, 16'd2);    // fewer fails wins
        send_request(OP_SELECT, 4'd0, 1'b0, 16'd0, 16'd0);
        send_request(OP_COMPLETE, 4'd12, 1'b0, 16'd0, 16'd0);  // zero threshold: due at once
        send_request(OP_SELECT, 4'd0, 1'b0, 16'd0, 16'd0);
        send_request(OP_FAIL, 4'd7, 1'b0, 16'd0, 16'd0);
        send_request(OP_SELECT, 4'd0, 1'b0, 16'd0, 16'd0);
        send_request(OP_TICK, 4'd0, 1'b0, 16'd0, 16'd0);

        reconfigure(0, 5, 3);
        send_request(OP_REPORT, 4'd0, 1'b1, 16'd0, 16'd0);
        send_request(OP_SELECT, 4'd0, 1'b0, 16'd0, 16'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            reconfigure(phase_servers[p], phase_done[p], phase_ticks[p]);
            sender_gaps = (p != 4) && (p != PHASES - 1);
            calm        = (p == PHASES - 1);
            if (p == 2)
                want_long_hold = 1'b1;
            repeat (ITEMS_PER_PHASE) random_request();
        end

        in_valid = 1'b0;
        wait (outstanding == 0);
        repeat (30) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
